>>> design/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants for the suffix array builder.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int MAX_TEXT_DEF = 1024;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
    logic       end_of_text;
    logic [9:0] sorted_index;
  } in_item_t;

  typedef struct packed {
    logic [9:0] suffix_start;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_INIT_R, S_INIT_W, S_SORT, S_SEG, S_PICK,
    S_RA, S_RB, S_KA, S_KB, S_CMP, S_CPR, S_CPW,
    S_KEY_R1, S_KEY_R2, S_KEY_W, S_REN_R1, S_REN_R2, S_REN_W, S_ROUND
  } state_t;

endpackage

>>> design/sab_ram.sv
// ----------------------------------------------------------------------------
// sab_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> design/suffix_array_builder_top.sv
// ----------------------------------------------------------------------------
// suffix_array_builder_top
// Loads a text and builds its suffix array by prefix doubling in RAM.
// ----------------------------------------------------------------------------
// A push's result strobes on out_valid in the cycle after it is accepted.
// A valid read passes through S_RD for one RAM read of the order table. A push marked
// end_of_text starts construction and holds busy high until the array is
// built: a seed walk over the text, a first merge sort, then for each of
// ceil(log2 N) doubling rounds a walk to form pair keys, a merge sort of
// ceil(log2 N) passes that reads order entries and keys one at a time
// through the single read port of the order and key RAMs, and a renumber walk.
// Results are not back-pressured: out_valid is high for exactly one cycle.
module suffix_array_builder_top
  import sab_pkg::*;
#(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = $clog2(MAX_TEXT);
  localparam int LW = $clog2(MAX_TEXT + 1);
  localparam int CW = LW + 2;
  localparam int RW = (LW > 9) ? LW : 9;
  localparam int KW = 2 * RW;

  state_t state_r, state_nxt;

  logic [LW-1:0] len_r, len_nxt;
  logic          built_r, built_nxt;
  logic          sel_r, sel_nxt;
  logic          phase_r, phase_nxt;
  logic [CW-1:0] w_r, w_nxt, lo_r, lo_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt, k_r, k_nxt, h_r, h_nxt, i_r, i_nxt;
  logic [AW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic [KW-1:0] ka_r, ka_nxt, prev_r, prev_nxt;
  logic [RW-1:0] r1_r, r1_nxt, rcnt_r, rcnt_nxt;
  logic          hasb_r, hasb_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic          txt_we, rank_we, key_we, ord0_we, ord1_we;
  logic [AW-1:0] txt_wa, rank_wa, key_wa, ord_wa;
  logic [AW-1:0] txt_ra, rank_ra, key_ra, ord_ra;
  logic [7:0]    txt_wd, txt_rd;
  logic [RW-1:0] rank_wd, rank_rd;
  logic [KW-1:0] key_wd, key_rd;
  logic [AW-1:0] ord_wd, ord0_rd, ord1_rd, src_rd;

  logic          accept;
  logic [CW-1:0] n;
  logic [LW-1:0] len_eff;
  logic [CW-1:0] lo_w, lo_2w, pos_h;
  logic [RW-1:0] r_new;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign n      = CW'(len_r);
  assign src_rd = sel_r ? ord1_rd : ord0_rd;
  assign lo_w   = lo_r + w_r;
  assign lo_2w  = lo_r + (w_r << 1);
  assign pos_h  = i_r + h_r;
  assign len_eff = built_r ? '0 : len_r;
  assign r_new  = ((i_r == '0) || (key_rd != prev_r)) ? rcnt_r + RW'(1) : rcnt_r;

  sab_ram #(.WIDTH(8),  .DEPTH(MAX_TEXT)) u_txt (
    .clk, .we(txt_we), .waddr(txt_wa), .wdata(txt_wd), .raddr(txt_ra), .rdata_r(txt_rd));
  sab_ram #(.WIDTH(RW), .DEPTH(MAX_TEXT)) u_rank (
    .clk, .we(rank_we), .waddr(rank_wa), .wdata(rank_wd), .raddr(rank_ra),
    .rdata_r(rank_rd));
  sab_ram #(.WIDTH(KW), .DEPTH(MAX_TEXT)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata_r(key_rd));
  sab_ram #(.WIDTH(AW), .DEPTH(MAX_TEXT)) u_ord0 (
    .clk, .we(ord0_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata_r(ord0_rd));
  sab_ram #(.WIDTH(AW), .DEPTH(MAX_TEXT)) u_ord1 (
    .clk, .we(ord1_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata_r(ord1_rd));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.op == OP_READ) begin
            if (built_r && ({22'd0, in_item.sorted_index} < 32'(len_r))) state_nxt = S_RD;
          end else if (in_item.end_of_text) begin
            state_nxt = S_INIT_R;
          end
        end
      end
      S_RD:     state_nxt = S_IDLE;
      S_INIT_R: state_nxt = S_INIT_W;
      S_INIT_W: state_nxt = (i_r + CW'(1) < n) ? S_INIT_R : S_SORT;
      S_SORT: begin
        if (w_r < n) state_nxt = S_SEG;
        else if (phase_r) state_nxt = S_REN_R1;
        else state_nxt = S_ROUND;
      end
      S_SEG:    state_nxt = (lo_r >= n) ? S_SORT : S_PICK;
      S_PICK: begin
        if (a_r < mid_r && b_r < hi_r) state_nxt = S_RA;
        else if (a_r < mid_r || b_r < hi_r) state_nxt = S_CPR;
        else state_nxt = S_SEG;
      end
      S_RA:     state_nxt = S_RB;
      S_RB:     state_nxt = S_KA;
      S_KA:     state_nxt = S_KB;
      S_KB:     state_nxt = S_CMP;
      S_CMP:    state_nxt = S_PICK;
      S_CPR:    state_nxt = S_CPW;
      S_CPW:    state_nxt = S_PICK;
      S_KEY_R1: state_nxt = S_KEY_R2;
      S_KEY_R2: state_nxt = S_KEY_W;
      S_KEY_W:  state_nxt = (i_r + CW'(1) < n) ? S_KEY_R1 : S_SORT;
      S_REN_R1: state_nxt = S_REN_R2;
      S_REN_R2: state_nxt = S_REN_W;
      S_REN_W:  state_nxt = (i_r + CW'(1) < n) ? S_REN_R1 : S_ROUND;
      S_ROUND:  state_nxt = (h_r < n) ? S_KEY_R1 : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    len_nxt = len_r;       built_nxt = built_r;   sel_nxt = sel_r;
    phase_nxt = phase_r;   w_nxt = w_r;           lo_nxt = lo_r;
    mid_nxt = mid_r;       hi_nxt = hi_r;         a_nxt = a_r;
    b_nxt = b_r;           k_nxt = k_r;           h_nxt = h_r;
    i_nxt = i_r;           ia_nxt = ia_r;         ib_nxt = ib_r;
    ka_nxt = ka_r;         prev_nxt = prev_r;     r1_nxt = r1_r;
    rcnt_nxt = rcnt_r;     hasb_nxt = hasb_r;
    out_valid_nxt = 1'b0;  out_item_nxt = out_item_r;
    txt_we = 1'b0;  txt_wa = AW'(len_eff);  txt_wd = in_item.text_byte;
    txt_ra = AW'(i_r);
    rank_we = 1'b0; rank_wa = AW'(i_r);     rank_wd = RW'(txt_rd) + RW'(1);
    rank_ra = AW'(i_r);
    key_we = 1'b0;  key_wa = AW'(i_r);      key_wd = {rank_wd, RW'(0)};
    key_ra = ia_r;
    ord0_we = 1'b0; ord1_we = 1'b0;         ord_wa = AW'(k_r);
    ord_wd = AW'(i_r);                      ord_ra = AW'(a_r);
    unique case (state_r)
      S_IDLE: begin
        ord_ra = AW'(in_item.sorted_index);
        if (accept) begin
          out_item_nxt.suffix_start = '0;
          out_item_nxt.status = ST_OK;
          if (in_item.op == OP_PUSH) begin
            out_valid_nxt = 1'b1;
            built_nxt = 1'b0;
            if (CW'(len_eff) < CW'(MAX_TEXT)) begin
              txt_we  = 1'b1;
              len_nxt = len_eff + LW'(1);
            end else begin
              len_nxt = len_eff;
              out_item_nxt.status = ST_FULL;
            end
            i_nxt = '0;
            sel_nxt = 1'b0;
            phase_nxt = 1'b0;
          end else if (!built_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt.status = ST_NOT_BUILT;
          end else if (!({22'd0, in_item.sorted_index} < 32'(len_r))) begin
            out_valid_nxt = 1'b1;
            out_item_nxt.status = ST_RANGE;
          end
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_item_nxt.suffix_start = 10'(src_rd);
        out_item_nxt.status = ST_OK;
      end
      S_INIT_R: ;
      S_INIT_W: begin
        rank_we = 1'b1;
        key_we  = 1'b1;
        ord0_we = 1'b1;
        ord_wa  = AW'(i_r);
        i_nxt   = i_r + CW'(1);
        w_nxt   = CW'(1);
        h_nxt   = CW'(1);
      end
      S_SORT: begin
        lo_nxt = '0;
        // rewind the element index for the renumber walk
        if (!(w_r < n)) i_nxt = '0;
      end
      S_SEG: begin
        if (lo_r >= n) begin
          sel_nxt = ~sel_r;
          w_nxt = w_r << 1;
        end else begin
          mid_nxt = (lo_w < n) ? lo_w : n;
          hi_nxt  = (lo_2w < n) ? lo_2w : n;
          a_nxt = lo_r;
          b_nxt = (lo_w < n) ? lo_w : n;
          k_nxt = lo_r;
        end
      end
      S_PICK: begin
        if (!(a_r < mid_r) && !(b_r < hi_r)) lo_nxt = lo_2w;
      end
      S_RA: ord_ra = AW'(a_r);
      S_RB: begin
        ord_ra = AW'(b_r);
        ia_nxt = src_rd;
      end
      S_KA: begin
        ib_nxt = src_rd;
        key_ra = ia_r;
      end
      S_KB: begin
        key_ra = ib_r;
        ka_nxt = key_rd;
      end
      S_CMP: begin
        ord0_we = sel_r;
        ord1_we = ~sel_r;
        k_nxt = k_r + CW'(1);
        // Stable: take b only when strictly smaller
        if (key_rd < ka_r) begin
          ord_wd = ib_r;
          b_nxt = b_r + CW'(1);
        end else begin
          ord_wd = ia_r;
          a_nxt = a_r + CW'(1);
        end
      end
      S_CPR: ord_ra = (a_r < mid_r) ? AW'(a_r) : AW'(b_r);
      S_CPW: begin
        ord0_we = sel_r;
        ord1_we = ~sel_r;
        ord_wd = src_rd;
        k_nxt = k_r + CW'(1);
        if (a_r < mid_r) a_nxt = a_r + CW'(1);
        else b_nxt = b_r + CW'(1);
      end
      S_KEY_R1: rank_ra = AW'(i_r);
      S_KEY_R2: begin
        r1_nxt = rank_rd;
        hasb_nxt = (pos_h < n);
        rank_ra = AW'(pos_h);
      end
      S_KEY_W: begin
        key_we = 1'b1;
        key_wd = {r1_r, hasb_r ? rank_rd : RW'(0)};
        i_nxt = i_r + CW'(1);
        w_nxt = CW'(1);
        phase_nxt = 1'b1;
      end
      S_REN_R1: ord_ra = AW'(i_r);
      S_REN_R2: begin
        ia_nxt = src_rd;
        key_ra = src_rd;
      end
      S_REN_W: begin
        rank_we = 1'b1;
        rank_wa = ia_r;
        rank_wd = r_new;
        rcnt_nxt = r_new;
        prev_nxt = key_rd;
        i_nxt = i_r + CW'(1);
        if (!(i_r + CW'(1) < n)) h_nxt = h_r << 1;
      end
      S_ROUND: begin
        i_nxt = '0;
        rcnt_nxt = '0;
        if (!(h_r < n)) built_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;   phase_r <= phase_nxt; w_r <= w_nxt;     lo_r <= lo_nxt;
    mid_r <= mid_nxt;   hi_r <= hi_nxt;       a_r <= a_nxt;     b_r <= b_nxt;
    k_r <= k_nxt;       h_r <= h_nxt;         i_r <= i_nxt;     ia_r <= ia_nxt;
    ib_r <= ib_nxt;     ka_r <= ka_nxt;       prev_r <= prev_nxt;
    r1_r <= r1_nxt;     rcnt_r <= rcnt_nxt;   hasb_r <= hasb_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept) || $past(state_r == S_RD)))
    else $error("result strobe without a transfer or read");
  a_built_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(built_r) |-> $past(accept && in_item.op == OP_PUSH))
    else $error("built flag cleared without a push");
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(len_r) <= CW'(MAX_TEXT))
    else $error("text length beyond capacity");
  a_merge_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PICK |-> k_r == a_r + b_r - mid_r)
    else $error("merge output count out of step");
`endif

endmodule

>>> dv/tb_suffix_array_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_suffix_array_builder_top
// Loads texts of random length and content, lets the block build each
// suffix array, and reads entries back. A prefix-doubling predictor inside a
// small scoreboard computes every push and read result and compares them
// with the block's strobed results in order.
// ----------------------------------------------------------------------------
module tb_suffix_array_builder_top;
  import sab_pkg::*;

  localparam int TEXT_CAP = MAX_TEXT_DEF;

  class sa_scoreboard;
    logic [7:0] text_mem[TEXT_CAP];
    int         order_tbl[TEXT_CAP];
    longint     rank_tbl[TEXT_CAP];
    longint     key_tbl[TEXT_CAP];
    int         text_len;
    bit         is_built;
    out_item_t  pending_q[$];
    int         mismatches;
    int         checked;
    int         pushes;
    int         reads;
    int         builds;

    function new();
      text_len = 0;
      is_built = 0;
      mismatches = 0;
      checked = 0;
      pushes = 0;
      reads = 0;
      builds = 0;
    endfunction

    // stable bottom-up merge of order_tbl by key_tbl
    function void sort_by_key(int n);
      int tmp[TEXT_CAP];
      int w, lo, mid, hi, a, b, k;
      for (w = 1; w < n; w = w * 2) begin
        for (lo = 0; lo < n; lo = lo + 2 * w) begin
          mid = (lo + w < n) ? lo + w : n;
          hi = (lo + 2 * w < n) ? lo + 2 * w : n;
          a = lo;
          b = mid;
          k = lo;
          while (a < mid && b < hi) begin
            if (key_tbl[order_tbl[b]] < key_tbl[order_tbl[a]]) begin
              tmp[k] = order_tbl[b];
              b++;
            end else begin
              tmp[k] = order_tbl[a];
              a++;
            end
            k++;
          end
          while (a < mid) begin
            tmp[k] = order_tbl[a];
            a++;
            k++;
          end
          while (b < hi) begin
            tmp[k] = order_tbl[b];
            b++;
            k++;
          end
        end
        for (int i = 0; i < n; i++) order_tbl[i] = tmp[i];
      end
    endfunction

    function void build_suffix_order();
      int n, h, p;
      longint r, prev, second;
      n = text_len;
      for (int i = 0; i < n; i++) begin
        order_tbl[i] = i;
        rank_tbl[i] = longint'(text_mem[i]) + 1;
        key_tbl[i] = rank_tbl[i];
      end
      sort_by_key(n);
      h = 1;
      while (h < n) begin
        for (p = 0; p < n; p++) begin
          // a missing second half ranks below every real rank
          second = (p + h < n) ? rank_tbl[p + h] : 0;
          key_tbl[p] = (rank_tbl[p] << 32) | second;
        end
        sort_by_key(n);
        r = 0;
        prev = 0;
        for (int i = 0; i < n; i++) begin
          p = order_tbl[i];
          if (i == 0 || key_tbl[p] != prev) r++;
          prev = key_tbl[p];
          rank_tbl[p] = r;
        end
        h = h * 2;
      end
      is_built = 1;
      builds++;
    endfunction

    function void note_input(in_item_t it);
      out_item_t res;
      res.suffix_start = '0;
      res.status = ST_OK;
      if (it.op == OP_PUSH) begin
        pushes++;
        if (is_built) begin
          is_built = 0;
          text_len = 0;
        end
        if (text_len < TEXT_CAP) begin
          text_mem[text_len] = it.text_byte;
          text_len++;
        end else begin
          res.status = ST_FULL;
        end
        if (it.end_of_text) build_suffix_order();
      end else begin
        reads++;
        if (!is_built) res.status = ST_NOT_BUILT;
        else if (int'(it.sorted_index) >= text_len) res.status = ST_RANGE;
        else res.suffix_start = 10'(order_tbl[it.sorted_index]);
      end
      pending_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result start=%0d status=%0d",
                   got.suffix_start, got.status);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.suffix_start !== want.suffix_start || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: start exp %0d got %0d, status exp %0d got %0d",
                   checked, want.suffix_start, got.suffix_start, want.status, got.status);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  sa_scoreboard sb;
  int           idle_pct;

  suffix_array_builder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // hold the transfer until the block takes it
  task automatic send(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    in_item_t it;
    it = '0;
    it.op = OP_PUSH;
    it.text_byte = b;
    it.end_of_text = last;
    it.sorted_index = 10'($urandom);
    send(it);
  endtask

  task automatic read_entry(logic [9:0] idx);
    in_item_t it;
    it = '0;
    it.op = OP_READ;
    it.text_byte = 8'($urandom);
    it.end_of_text = 1'($urandom);
    it.sorted_index = idx;
    send(it);
  endtask

  function automatic logic [7:0] pick_byte(int alpha);
    case (alpha)
      0: return ($urandom_range(1) == 0) ? 8'h00 : 8'hff;
      1: return 8'($urandom_range(0, 2));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_text();
    int len, alpha;
    len = ($urandom_range(9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
    alpha = $urandom_range(2);
    for (int i = 0; i < len; i++) begin
      // now and then poke a read into a text still loading
      if ($urandom_range(29) == 0) read_entry(10'($urandom));
      push_byte(pick_byte(alpha), i == len - 1);
    end
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(4) == 0) read_entry(10'($urandom));
      else read_entry(10'($urandom_range(0, len - 1)));
    end
  endtask

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int sent;
    sb = new();
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reads before any build, one-byte text, zero/0xff text
    read_entry(10'd0);
    read_entry(10'd1023);
    push_byte(8'h00, 1'b1);
    read_entry(10'd0);
    read_entry(10'd1);
    read_entry(10'd1023);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    read_entry(10'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b1);
    for (int i = 0; i < 6; i++) read_entry(10'(i));

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: idle_pct = 67;
        3: idle_pct = 19;
        default: idle_pct = 0;
      endcase
      while (sent < (phase + 1) * 240) begin
        int before_cnt;
        before_cnt = sb.pushes + sb.reads;
        random_text();
        sent += sb.pushes + sb.reads - before_cnt;
      end
    end

    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d pushes, %0d reads and %0d builds; %0d results compared.",
             sb.pushes, sb.reads, sb.builds, sb.checked);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("Mismatches: %0d", sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
